FILE: rtl/c2d_pkg.sv
// shared constants, types and helpers for the 2d convolution stream core
package c2d_pkg;

    // default build limits
    localparam int MAX_K_DEF    = 7;
    localparam int MAX_COLS_DEF = 2048;
    localparam int MAX_ROWS_DEF = 4096;

    // fixed field widths
    localparam int PIX_W      = 16;
    localparam int TAP_W      = 16;
    localparam int PROD_W     = 32;
    localparam int SUM_W      = 37;
    localparam int KIND_W     = 2;
    localparam int TIDX_W     = 6;
    localparam int ROWS_CFG_W = 13;
    localparam int COLS_CFG_W = 12;
    localparam int KSZ_CFG_W  = 3;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;

    // word kinds
    localparam logic [KIND_W-1:0] KIND_TAP   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAIN = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KSIZE = 2'd2;

    // register reset values
    localparam logic [ROWS_CFG_W-1:0] ROWS_RST = 13'd4096;
    localparam logic [COLS_CFG_W-1:0] COLS_RST = 12'd2048;
    localparam logic [KSZ_CFG_W-1:0]  KSZ_RST  = 3'd3;

    // line buffer strobes
    typedef struct packed {
        logic rd;
        logic wr;
    } c2d_lb_ctl_t;

    // zero acts as one, large values saturate at the limit
    function automatic logic [31:0] clamp_cfg(logic [31:0] v, logic [31:0] hi);
        logic [31:0] r;
        if (v == 32'd0) begin
            r = 32'd1;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: rtl/conv2d_zero_padded_stream_core.sv
// top level of the zero padded 2d convolution stream core
//
//  port group   dir  handshake            payload
//  s_*          in   s_valid / s_ready    s_kind s_pixel s_tap_index s_tap_value
//  m_*          out  m_valid / m_ready    m_sum_value m_out_row m_out_col m_frame_end
//  cfg_*        in   cfg_wr_en            cfg_index cfg_data
//
// one word is taken per cycle while s_ready is high; the line memory is read when a word is taken and
// written back from the stage-one registers, with forwarding for a one-column frame.
// a result passes through the pipeline stages into the output register, or into the skid stage.
// reset clears positions, registers and handshake state; the memory needs no clearing.
// a full skid stage stops the whole pipeline, and s_ready is low for one cycle
// after each register write.
module conv2d_zero_padded_stream_core #(
    parameter int MAX_K    = c2d_pkg::MAX_K_DEF,
    parameter int MAX_COLS = c2d_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = c2d_pkg::MAX_ROWS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [c2d_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [c2d_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [c2d_pkg::KIND_W-1:0]          s_kind,
    input  logic signed [c2d_pkg::PIX_W-1:0]    s_pixel,
    input  logic [c2d_pkg::TIDX_W-1:0]          s_tap_index,
    input  logic signed [c2d_pkg::TAP_W-1:0]    s_tap_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [c2d_pkg::SUM_W-1:0]    m_sum_value,
    output logic [$clog2(MAX_ROWS)-1:0]         m_out_row,
    output logic [$clog2(MAX_COLS)-1:0]         m_out_col,
    output logic                                m_frame_end
);
    localparam int WIN    = 2*(MAX_K/2)+1;
    localparam int KW     = $clog2(MAX_K+1);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int RCNT_W = $clog2(MAX_ROWS+1);
    localparam int CCNT_W = $clog2(MAX_COLS+1);
    localparam int LAG_W  = $clog2((MAX_K/2)*(MAX_COLS+1)+2);
    localparam int NTAPS  = MAX_K*MAX_K;
    localparam int TSEL_W = (NTAPS > 1) ? $clog2(NTAPS) : 1;
    localparam int PW     = c2d_pkg::PIX_W;
    localparam int SW     = c2d_pkg::SUM_W;

    // configuration
    logic [c2d_pkg::ROWS_CFG_W-1:0] rows_cfg_reg;
    logic [c2d_pkg::COLS_CFG_W-1:0] cols_cfg_reg;
    logic [c2d_pkg::KSZ_CFG_W-1:0]  ksz_cfg_reg;
    logic                           cfg_hit;
    logic                           settle_reg;
    logic [31:0]                    rows_c;
    logic [31:0]                    cols_c;
    logic [31:0]                    k_c;
    logic [RCNT_W-1:0]              rows_n_next, rows_n_reg;
    logic [CCNT_W-1:0]              cols_n_next, cols_n_reg;
    logic [ROW_W-1:0]               rows_last_next, rows_last_reg;
    logic [COL_W-1:0]               cols_last_next, cols_last_reg;
    logic [KW-1:0]                  k_next, k_reg;
    logic [KW-1:0]                  h_next, h_reg;
    logic [LAG_W-1:0]               lag_next, lag_reg;

    // input side
    logic                           en;
    logic                           acc;
    logic                           acc_adv;
    logic                           acc_tap;
    logic                           emit;
    logic                           fe;
    logic signed [PW-1:0]           sample;
    logic [LAG_W-1:0]               pre_reg;
    logic [COL_W-1:0]               in_col_reg;
    logic [ROW_W-1:0]               r_reg;
    logic [COL_W-1:0]               c_reg;

    // pipeline
    logic                           v1_reg, ov1_reg, ov2_reg, ov3_reg, ov4_reg, ov5_reg;
    logic signed [PW-1:0]           samp1_reg;
    logic [COL_W-1:0]               addr1_reg;
    logic [ROW_W-1:0]               r1_reg, r2_reg, r3_reg, r4_reg, r5_reg;
    logic [COL_W-1:0]               c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
    logic                           fe1_reg, fe2_reg, fe3_reg, fe4_reg, fe5_reg;
    logic [WIN-1:0]                 row_ok_next, col_ok_next, row_ok2_reg, col_ok2_reg;
    c2d_pkg::c2d_lb_ctl_t           lb_ctl;
    logic signed [PW-1:0]           win [WIN][WIN];
    logic signed [SW-1:0]           sum5;

    // output and skid
    logic                           out_v_reg, skid_v_reg;
    logic signed [SW-1:0]           out_sum_reg, skid_sum_reg;
    logic [ROW_W-1:0]               out_r_reg, skid_r_reg;
    logic [COL_W-1:0]               out_c_reg, skid_c_reg;
    logic                           out_fe_reg, skid_fe_reg;

    // register writes
    assign cfg_hit = cfg_wr_en && (cfg_index == c2d_pkg::REG_ROWS ||
                     cfg_index == c2d_pkg::REG_COLS || cfg_index == c2d_pkg::REG_KSIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= c2d_pkg::ROWS_RST;
            cols_cfg_reg <= c2d_pkg::COLS_RST;
            ksz_cfg_reg  <= c2d_pkg::KSZ_RST;
            settle_reg   <= 1'b1;
        end else begin
            settle_reg <= cfg_wr_en;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    c2d_pkg::REG_ROWS:  rows_cfg_reg <= cfg_data[c2d_pkg::ROWS_CFG_W-1:0];
                    c2d_pkg::REG_COLS:  cols_cfg_reg <= cfg_data[c2d_pkg::COLS_CFG_W-1:0];
                    c2d_pkg::REG_KSIZE: ksz_cfg_reg  <= cfg_data[c2d_pkg::KSZ_CFG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // clamped geometry and output lag
    always_comb begin
        rows_c         = c2d_pkg::clamp_cfg(32'(rows_cfg_reg), 32'(MAX_ROWS));
        cols_c         = c2d_pkg::clamp_cfg(32'(cols_cfg_reg), 32'(MAX_COLS));
        k_c            = c2d_pkg::clamp_cfg(32'(ksz_cfg_reg), 32'(MAX_K));
        rows_n_next    = RCNT_W'(rows_c);
        cols_n_next    = CCNT_W'(cols_c);
        rows_last_next = ROW_W'(rows_c - 32'd1);
        cols_last_next = COL_W'(cols_c - 32'd1);
        k_next         = KW'(k_c);
        h_next         = KW'(k_c >> 1);
        lag_next       = LAG_W'(LAG_W'(h_next) * LAG_W'(cols_n_next) + LAG_W'(h_next));
    end

    always_ff @(posedge aclk) begin
        rows_n_reg    <= rows_n_next;
        cols_n_reg    <= cols_n_next;
        rows_last_reg <= rows_last_next;
        cols_last_reg <= cols_last_next;
        k_reg         <= k_next;
        h_reg         <= h_next;
        lag_reg       <= lag_next;
    end

    // input handshake and word decode
    assign en      = !skid_v_reg;
    assign s_ready = en && !settle_reg;
    assign acc     = s_valid && s_ready;
    assign acc_adv = acc && (s_kind == c2d_pkg::KIND_PIXEL || s_kind == c2d_pkg::KIND_DRAIN);
    assign acc_tap = acc && s_kind == c2d_pkg::KIND_TAP && 32'(s_tap_index) < NTAPS;
    assign emit    = pre_reg == lag_reg;
    assign fe      = emit && r_reg == rows_last_reg && c_reg == cols_last_reg;
    assign sample  = (s_kind == c2d_pkg::KIND_PIXEL) ? s_pixel : '0;

    // frame positions
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            pre_reg    <= '0;
            in_col_reg <= '0;
            r_reg      <= '0;
            c_reg      <= '0;
        end else if (acc_adv) begin
            if (fe) begin
                pre_reg    <= '0;
                in_col_reg <= '0;
                r_reg      <= '0;
                c_reg      <= '0;
            end else begin
                if (!emit) begin
                    pre_reg <= pre_reg + 1'b1;
                end
                in_col_reg <= (in_col_reg == cols_last_reg) ? '0 : in_col_reg + 1'b1;
                if (emit) begin
                    if (c_reg == cols_last_reg) begin
                        c_reg <= '0;
                        r_reg <= r_reg + 1'b1;
                    end else begin
                        c_reg <= c_reg + 1'b1;
                    end
                end
            end
        end
    end

    // pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            ov1_reg <= 1'b0;
            ov2_reg <= 1'b0;
            ov3_reg <= 1'b0;
            ov4_reg <= 1'b0;
            ov5_reg <= 1'b0;
        end else if (en) begin
            v1_reg  <= acc_adv;
            ov1_reg <= acc_adv && emit;
            ov2_reg <= ov1_reg;
            ov3_reg <= ov2_reg;
            ov4_reg <= ov3_reg;
            ov5_reg <= ov4_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (en) begin
            samp1_reg   <= sample;
            addr1_reg   <= in_col_reg;
            r1_reg      <= r_reg;
            c1_reg      <= c_reg;
            fe1_reg     <= fe;
            r2_reg      <= r1_reg;
            c2_reg      <= c1_reg;
            fe2_reg     <= fe1_reg;
            row_ok2_reg <= row_ok_next;
            col_ok2_reg <= col_ok_next;
            r3_reg      <= r2_reg;
            c3_reg      <= c2_reg;
            fe3_reg     <= fe2_reg;
            r4_reg      <= r3_reg;
            c4_reg      <= c3_reg;
            fe4_reg     <= fe3_reg;
            r5_reg      <= r4_reg;
            c5_reg      <= c4_reg;
            fe5_reg     <= fe4_reg;
        end
    end

    // window row n sits at image row r+h-n, column m at c+h-m
    always_comb begin
        logic [ROW_W:0] ra;
        logic [COL_W:0] ca;
        ra = (ROW_W+1)'(r1_reg) + (ROW_W+1)'(h_reg);
        ca = (COL_W+1)'(c1_reg) + (COL_W+1)'(h_reg);
        for (int n = 0; n < WIN; n++) begin
            row_ok_next[n] = ra >= (ROW_W+1)'(n) && (ra - (ROW_W+1)'(n)) < rows_n_reg;
            col_ok_next[n] = ca >= (COL_W+1)'(n) && (ca - (COL_W+1)'(n)) < cols_n_reg;
        end
    end

    // line memory and window
    assign lb_ctl.rd = acc_adv;
    assign lb_ctl.wr = en && v1_reg;

    c2d_linebuf #(
        .MAX_K    (MAX_K),
        .MAX_COLS (MAX_COLS)
    ) u_linebuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (lb_ctl),
        .rd_addr  (in_col_reg),
        .wr_addr  (addr1_reg),
        .wr_pixel (samp1_reg),
        .win      (win)
    );

    // taps, products and sums
    c2d_mac #(
        .MAX_K (MAX_K)
    ) u_mac (
        .aclk      (aclk),
        .en        (en),
        .tap_we    (acc_tap),
        .tap_sel   (TSEL_W'(s_tap_index)),
        .tap_value (s_tap_value),
        .k_size    (k_reg),
        .row_ok    (row_ok2_reg),
        .col_ok    (col_ok2_reg),
        .win       (win),
        .sum       (sum5)
    );

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (!out_v_reg || m_ready) begin
            if (skid_v_reg) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end else begin
                out_v_reg <= ov5_reg;
            end
        end else if (en && ov5_reg) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_v_reg || m_ready) begin
            if (skid_v_reg) begin
                out_sum_reg <= skid_sum_reg;
                out_r_reg   <= skid_r_reg;
                out_c_reg   <= skid_c_reg;
                out_fe_reg  <= skid_fe_reg;
            end else begin
                out_sum_reg <= sum5;
                out_r_reg   <= r5_reg;
                out_c_reg   <= c5_reg;
                out_fe_reg  <= fe5_reg;
            end
        end else if (en && ov5_reg) begin
            skid_sum_reg <= sum5;
            skid_r_reg   <= r5_reg;
            skid_c_reg   <= c5_reg;
            skid_fe_reg  <= fe5_reg;
        end
    end

    assign m_valid     = out_v_reg;
    assign m_sum_value = out_sum_reg;
    assign m_out_row   = out_r_reg;
    assign m_out_col   = out_c_reg;
    assign m_frame_end = out_fe_reg;

    // skid fills only behind a stalled output word
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_v_reg) |-> $past(out_v_reg && !m_ready))
        else $error("skid filled while output was free");

    // skid empties only when the output word is taken
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(skid_v_reg) |-> $past(m_ready))
        else $error("skid emptied without output transfer");

    // derived geometry settles before the next word
    a_cfg_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_ready)
        else $error("input taken right after register write");

    // no result before the window is filled
    a_lag: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_adv && !emit) |=> !ov1_reg)
        else $error("result issued inside the lag");

endmodule

FILE: rtl/c2d_linebuf.sv
// line memory with read-modify-write chaining and the sample window
module c2d_linebuf #(
    parameter int MAX_K    = c2d_pkg::MAX_K_DEF,
    parameter int MAX_COLS = c2d_pkg::MAX_COLS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  c2d_pkg::c2d_lb_ctl_t              ctl,
    input  logic [$clog2(MAX_COLS)-1:0]       rd_addr,
    input  logic [$clog2(MAX_COLS)-1:0]       wr_addr,
    input  logic signed [c2d_pkg::PIX_W-1:0]  wr_pixel,
    output logic signed [c2d_pkg::PIX_W-1:0]  win [2*(MAX_K/2)+1][2*(MAX_K/2)+1]
);
    localparam int WIN    = 2*(MAX_K/2)+1;
    localparam int NLINE  = (WIN > 1) ? WIN-1 : 1;
    localparam int ADDR_W = $clog2(MAX_COLS);
    localparam int PW     = c2d_pkg::PIX_W;
    localparam int WORD_W = NLINE*PW;

    logic [WORD_W-1:0]          mem [MAX_COLS];
    logic [WORD_W-1:0]          rd_word_reg;
    logic [WORD_W-1:0]          fwd_word_reg;
    logic [ADDR_W-1:0]          fwd_addr_reg;
    logic                       fwd_valid_reg;
    logic [WORD_W-1:0]          eff_word;
    logic [WORD_W-1:0]          wr_word;
    logic signed [PW-1:0]       column [WIN];
    logic signed [PW-1:0]       win_reg [WIN][WIN];

    // one word holds the same column of every buffered line
    always_ff @(posedge aclk) begin
        if (ctl.rd) begin
            rd_word_reg <= mem[rd_addr];
        end
        if (ctl.wr) begin
            mem[wr_addr] <= wr_word;
        end
    end

    // forward the last written word when the read raced its write
    always_comb begin
        eff_word = (fwd_valid_reg && fwd_addr_reg == wr_addr) ? fwd_word_reg : rd_word_reg;
    end

    // shift lines down by one, newest sample into line zero
    always_comb begin
        wr_word = eff_word;
        wr_word[PW-1:0] = wr_pixel;
        for (int n = 1; n < NLINE; n++) begin
            wr_word[n*PW +: PW] = eff_word[(n-1)*PW +: PW];
        end
    end

    // column entering the window, newest row first
    always_comb begin
        column[0] = wr_pixel;
        for (int n = 1; n < WIN; n++) begin
            column[n] = $signed(eff_word[(n-1)*PW +: PW]);
        end
    end

    // forwarding state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (ctl.wr) begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr) begin
            fwd_word_reg <= wr_word;
            fwd_addr_reg <= wr_addr;
        end
    end

    // window shift
    always_ff @(posedge aclk) begin
        if (ctl.wr) begin
            for (int n = 0; n < WIN; n++) begin
                win_reg[n][0] <= column[n];
                for (int m = 1; m < WIN; m++) begin
                    win_reg[n][m] <= win_reg[n][m-1];
                end
            end
        end
    end

    assign win = win_reg;

endmodule

FILE: rtl/c2d_mac.sv
// tap store, coefficient alignment and the multiply and adder tree
module c2d_mac #(
    parameter int MAX_K = c2d_pkg::MAX_K_DEF
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic                                   tap_we,
    input  logic [((MAX_K*MAX_K > 1) ? $clog2(MAX_K*MAX_K) : 1)-1:0] tap_sel,
    input  logic signed [c2d_pkg::TAP_W-1:0]       tap_value,
    input  logic [$clog2(MAX_K+1)-1:0]             k_size,
    input  logic [2*(MAX_K/2):0]                   row_ok,
    input  logic [2*(MAX_K/2):0]                   col_ok,
    input  logic signed [c2d_pkg::PIX_W-1:0]       win [2*(MAX_K/2)+1][2*(MAX_K/2)+1],
    output logic signed [c2d_pkg::SUM_W-1:0]       sum
);
    localparam int WIN    = 2*(MAX_K/2)+1;
    localparam int NTAPS  = MAX_K*MAX_K;
    localparam int KW     = $clog2(MAX_K+1);
    localparam int SW     = c2d_pkg::SUM_W;

    logic signed [c2d_pkg::TAP_W-1:0]  taps_reg [NTAPS];
    logic signed [c2d_pkg::TAP_W-1:0]  coef_next [WIN][WIN];
    logic signed [c2d_pkg::TAP_W-1:0]  coef_reg [WIN][WIN];
    logic signed [c2d_pkg::PROD_W-1:0] prod_reg [WIN][WIN];
    logic signed [SW-1:0]              rsum_next [WIN];
    logic signed [SW-1:0]              rsum_reg [WIN];
    logic signed [SW-1:0]              total_next;
    logic signed [SW-1:0]              total_reg;

    // tap store in row-major order
    always_ff @(posedge aclk) begin
        if (tap_we) begin
            taps_reg[tap_sel] <= tap_value;
        end
    end

    // window cell (n,m) meets tap (2h-n, 2h-m); cells outside the kernel get zero
    always_comb begin
        int hh;
        int ti;
        int tj;
        for (int n = 0; n < WIN; n++) begin
            for (int m = 0; m < WIN; m++) begin
                coef_next[n][m] = '0;
                for (int kk = 1; kk <= MAX_K; kk++) begin
                    hh = kk / 2;
                    ti = 2*hh - n;
                    tj = 2*hh - m;
                    if (k_size == KW'(kk) && ti >= 0 && tj >= 0 && ti < kk && tj < kk) begin
                        coef_next[n][m] = taps_reg[ti*kk + tj];
                    end
                end
            end
        end
    end

    // coefficients move with the pipeline so a later tap load misses earlier words
    always_ff @(posedge aclk) begin
        if (en) begin
            coef_reg <= coef_next;
        end
    end

    // products, padding cells forced to zero
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int n = 0; n < WIN; n++) begin
                for (int m = 0; m < WIN; m++) begin
                    if (row_ok[n] && col_ok[m]) begin
                        prod_reg[n][m] <= win[n][m] * coef_reg[n][m];
                    end else begin
                        prod_reg[n][m] <= '0;
                    end
                end
            end
        end
    end

    // row sums
    always_comb begin
        for (int n = 0; n < WIN; n++) begin
            rsum_next[n] = '0;
            for (int m = 0; m < WIN; m++) begin
                rsum_next[n] = rsum_next[n] + SW'(prod_reg[n][m]);
            end
        end
    end

    // total over rows
    always_comb begin
        total_next = '0;
        for (int n = 0; n < WIN; n++) begin
            total_next = total_next + rsum_reg[n];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rsum_reg  <= rsum_next;
            total_reg <= total_next;
        end
    end

    assign sum = total_reg;

endmodule

FILE: verif/conv2d_zero_padded_stream_core_test.sv
// testbench for the zero padded 2d convolution stream core
module conv2d_zero_padded_stream_core_test;

    localparam int MAX_K      = 7;
    localparam int MAX_COLS   = 2048;
    localparam int MAX_ROWS   = 4096;
    localparam int NUM_TAPS   = MAX_K * MAX_K;
    localparam int HIST_DEPTH = MAX_K * MAX_COLS + MAX_K + 1;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 12;
    localparam int EXTREME_WORDS = 64;
    localparam logic [c2d_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    // expected output pixels and a private copy of the core state
    class conv_scoreboard;
        typedef struct {
            logic signed [c2d_pkg::SUM_W-1:0] sum;
            logic [11:0] row;
            logic [10:0] col;
            logic        fend;
        } out_pixel_t;

        logic signed [15:0] taps[NUM_TAPS];
        logic signed [15:0] hist[HIST_DEPTH];
        int unsigned in_pos;
        int unsigned rows_reg, cols_reg, ksz_reg;
        out_pixel_t due_pixels[$];
        int errors;

        function new();
            rows_reg = 4096;
            cols_reg = 2048;
            ksz_reg  = 3;
            in_pos   = 0;
            errors   = 0;
        endfunction

        function int unsigned fit(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            return (v > hi) ? hi : v;
        endfunction

        function void write_reg(logic [c2d_pkg::CFG_IDX_W-1:0] idx,
                                logic [c2d_pkg::CFG_W-1:0] val);
            case (idx)
                c2d_pkg::REG_ROWS:  rows_reg = val[12:0];
                c2d_pkg::REG_COLS:  cols_reg = val[11:0];
                c2d_pkg::REG_KSIZE: ksz_reg  = val[2:0];
                default:   return;
            endcase
            in_pos = 0;
        endfunction

        // predict the result of one accepted word
        function void note_word(logic [c2d_pkg::KIND_W-1:0] kind, logic signed [15:0] pixel,
                                logic [5:0] tidx, logic signed [15:0] tval);
            int unsigned rows, cols, k, h, total, lag, p, r, c, pos;
            int rr, cc;
            longint acc;
            out_pixel_t o;
            rows = fit(rows_reg, MAX_ROWS);
            cols = fit(cols_reg, MAX_COLS);
            k = fit(ksz_reg, MAX_K);
            h = k / 2;
            total = rows * cols;
            lag = h * cols + h;
            acc = 0;
            if (kind == c2d_pkg::KIND_TAP) begin
                if (tidx < NUM_TAPS) taps[tidx] = tval;
                return;
            end
            if (kind == KIND_UNUSED) return;
            if (in_pos < total)
                hist[in_pos % HIST_DEPTH] = (kind == c2d_pkg::KIND_PIXEL) ? pixel : 16'sd0;
            in_pos++;
            if (in_pos - 1 < lag) return;
            p = in_pos - 1 - lag;
            r = p / cols;
            c = p % cols;
            for (int i = 0; i < k; i++) begin
                rr = r + i - h;
                if (rr < 0 || rr >= rows) continue;
                for (int j = 0; j < k; j++) begin
                    cc = c + j - h;
                    if (cc < 0 || cc >= cols) continue;
                    pos = rr * cols + cc;
                    acc += longint'(hist[pos % HIST_DEPTH]) * longint'(taps[i * k + j]);
                end
            end
            o.sum  = acc[c2d_pkg::SUM_W-1:0];
            o.row  = r[11:0];
            o.col  = c[10:0];
            o.fend = (p + 1 == total);
            due_pixels.push_back(o);
            if (p + 1 == total) in_pos = 0;
        endfunction

        function void check_pixel(logic signed [c2d_pkg::SUM_W-1:0] sum, logic [11:0] row,
                                  logic [10:0] col, logic fend);
            out_pixel_t o;
            if (due_pixels.size() == 0) begin
                $error("unexpected output pixel row %0d col %0d", row, col);
                errors++;
                return;
            end
            o = due_pixels.pop_front();
            if (sum !== o.sum) begin
                $error("sum_value expected %0d actual %0d", o.sum, sum);
                errors++;
            end
            if (row !== o.row) begin
                $error("out_row expected %0d actual %0d", o.row, row);
                errors++;
            end
            if (col !== o.col) begin
                $error("out_col expected %0d actual %0d", o.col, col);
                errors++;
            end
            if (fend !== o.fend) begin
                $error("frame_end expected %0d actual %0d", o.fend, fend);
                errors++;
            end
        endfunction
    endclass

    logic aclk, aresetn;
    logic cfg_wr_en;
    logic [c2d_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [c2d_pkg::CFG_W-1:0] cfg_data;
    logic s_valid, s_ready;
    logic [c2d_pkg::KIND_W-1:0] s_kind;
    logic signed [15:0] s_pixel;
    logic [5:0] s_tap_index;
    logic signed [15:0] s_tap_value;
    logic m_valid, m_ready;
    logic signed [c2d_pkg::SUM_W-1:0] m_sum_value;
    logic [11:0] m_out_row;
    logic [10:0] m_out_col;
    logic m_frame_end;

    conv_scoreboard sb;
    bit long_hold_done;
    int random_words;

    conv2d_zero_padded_stream_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_pixel(s_pixel),
        .s_tap_index(s_tap_index), .s_tap_value(s_tap_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_sum_value(m_sum_value),
        .m_out_row(m_out_row), .m_out_col(m_out_col), .m_frame_end(m_frame_end)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // offer one word, wait for it to be taken, then predict
    task automatic send_word(logic [c2d_pkg::KIND_W-1:0] kind, logic signed [15:0] pixel,
                             logic [5:0] tidx, logic signed [15:0] tval);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_pixel     <= pixel;
        s_tap_index <= tidx;
        s_tap_value <= tval;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        sb.note_word(kind, pixel, tidx, tval);
        @(negedge aclk);
    endtask

    // wait until the core is empty
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.due_pixels.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // write all three registers while idle
    task automatic program_frame(int unsigned rows, int unsigned cols, int unsigned ksz);
        logic [c2d_pkg::CFG_W-1:0] vals[3];
        logic [c2d_pkg::CFG_IDX_W-1:0] idxs[3];
        settle();
        vals = '{rows[c2d_pkg::CFG_W-1:0], cols[c2d_pkg::CFG_W-1:0], ksz[c2d_pkg::CFG_W-1:0]};
        idxs = '{c2d_pkg::REG_ROWS, c2d_pkg::REG_COLS, c2d_pkg::REG_KSIZE};
        for (int n = 0; n < 3; n++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idxs[n];
            cfg_data  <= vals[n];
            sb.write_reg(idxs[n], vals[n]);
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // one frame of pixels then drains, with noise, optional truncation and a word cap
    task automatic stream_frame(bit cut_short, bit noisy, int unsigned max_words);
        int unsigned rows, cols, k, total, n_words, stop_at;
        logic signed [15:0] px;
        rows = sb.fit(sb.rows_reg, MAX_ROWS);
        cols = sb.fit(sb.cols_reg, MAX_COLS);
        k = sb.fit(sb.ksz_reg, MAX_K);
        total = rows * cols;
        n_words = total + (k / 2) * cols + k / 2;
        stop_at = cut_short ? $urandom_range(0, n_words - 1) : n_words;
        if (max_words != 0 && stop_at > max_words) stop_at = max_words;
        for (int unsigned w = 0; w < stop_at; w++) begin
            if (noisy && $urandom_range(0, 19) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    send_word(KIND_UNUSED, 16'($urandom), 6'($urandom), 16'($urandom));
                else
                    send_word(c2d_pkg::KIND_TAP, 16'($urandom), 6'($urandom_range(0, 63)),
                              16'($urandom));
            end
            px = 16'($urandom);
            if (w < total)
                send_word((noisy && $urandom_range(0, 19) == 0) ?
                          c2d_pkg::KIND_DRAIN : c2d_pkg::KIND_PIXEL,
                          px, 6'($urandom), 16'($urandom));
            else
                send_word((noisy && $urandom_range(0, 9) == 0) ?
                          c2d_pkg::KIND_PIXEL : c2d_pkg::KIND_DRAIN,
                          px, 6'($urandom), 16'($urandom));
            random_words++;
        end
    endtask

    // result side with random stalls and one long hold off
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!long_hold_done && sb.due_pixels.size() > 0) begin
                stall = 400;
                long_hold_done = 1'b1;
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            forever begin
                @(posedge aclk);
                if (m_valid) break;
            end
            sb.check_pixel(m_sum_value, m_out_row, m_out_col, m_frame_end);
        end
    end

    // stimulus
    initial begin
        sb = new();
        long_hold_done = 1'b0;
        random_words = 0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = c2d_pkg::REG_ROWS;
        cfg_data = '0;
        s_valid = 1'b0;
        s_kind = c2d_pkg::KIND_DRAIN;
        s_pixel = '0;
        s_tap_index = '0;
        s_tap_value = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // every tap written before any window is read, with both extremes
        for (int t = 0; t < NUM_TAPS; t++)
            send_word(c2d_pkg::KIND_TAP, 16'($urandom), t[5:0],
                      (t % 3 == 0) ? 16'sh8000 : (t % 3 == 1) ? 16'sh7fff : 16'($urandom));
        send_word(c2d_pkg::KIND_TAP, 16'sh7fff, 6'd63, 16'sh1234);
        send_word(KIND_UNUSED, 16'sh8000, 6'd0, 16'sh0000);

        // small frame on reset kernel: extreme pixels, drain inside, pixel past frame
        program_frame(3, 4, 3);
        send_word(c2d_pkg::KIND_PIXEL, 16'sh8000, 6'd0, 16'sd0);
        send_word(c2d_pkg::KIND_PIXEL, 16'sh7fff, 6'd0, 16'sd0);
        send_word(c2d_pkg::KIND_DRAIN, 16'sh7fff, 6'd0, 16'sd0);
        for (int n = 0; n < 9; n++)
            send_word(c2d_pkg::KIND_PIXEL, (n % 2) ? 16'sh8000 : 16'sh7fff, 6'd0, 16'sd0);
        send_word(c2d_pkg::KIND_PIXEL, 16'sh7fff, 6'd0, 16'sd0);
        for (int n = 0; n < 4; n++) send_word(c2d_pkg::KIND_DRAIN, 16'sd0, 6'd0, 16'sd0);

        // register extremes: zero values and values past the limits
        program_frame(0, 0, 0);
        stream_frame(1'b0, 1'b0, 0);
        program_frame(8191, 1, 7);
        stream_frame(1'b0, 1'b0, EXTREME_WORDS);
        program_frame(1, 4095, 1);
        stream_frame(1'b0, 1'b0, EXTREME_WORDS);
        program_frame(2, 9, 7);
        stream_frame(1'b0, 1'b0, 0);

        // random frames, mostly well formed
        while (random_words < 900) begin
            program_frame($urandom_range(0, 7), $urandom_range(0, 12), $urandom_range(0, 7));
            stream_frame($urandom_range(0, 7) == 0, $urandom_range(0, 3) != 0, 0);
            if ($urandom_range(0, 2) == 0) stream_frame(1'b0, 1'b1, 0);
        end

        settle();
        if (sb.errors == 0 && sb.due_pixels.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/c2d_pkg.sv
rtl/c2d_linebuf.sv
rtl/c2d_mac.sv
rtl/conv2d_zero_padded_stream_core.sv
verif/conv2d_zero_padded_stream_core_test.sv
